/* hw/rtl/rzc_pkg.sv */
`timescale 1ns / 1ps

package rzc_pkg;

  typedef enum logic [1:0] {
    ZONE_FAR    = 2'd0,
    ZONE_DETECT = 2'd1,
    ZONE_CLOSE  = 2'd2
  } zone_t;

  localparam int DistWidth   = 12;
  localparam int CountWidth  = 8;
  localparam int SampleWidth = 16;
  localparam int IndexWidth  = 3;

  typedef logic [DistWidth-1:0]   dist_t;
  typedef logic [CountWidth-1:0]  count_t;
  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [IndexWidth-1:0]  reg_index_t;

  localparam reg_index_t REG_CLOSE_ENTER    = 3'd0;
  localparam reg_index_t REG_CLOSE_EXIT     = 3'd1;
  localparam reg_index_t REG_DETECT_ENTER   = 3'd2;
  localparam reg_index_t REG_DETECT_EXIT    = 3'd3;
  localparam reg_index_t REG_VALID_LIMIT    = 3'd4;
  localparam reg_index_t REG_CLOSE_CONFIRM  = 3'd5;
  localparam reg_index_t REG_DETECT_CONFIRM = 3'd6;
  localparam reg_index_t REG_FAR_CONFIRM    = 3'd7;

  localparam dist_t  RST_CLOSE_ENTER    = 12'd60;
  localparam dist_t  RST_CLOSE_EXIT     = 12'd70;
  localparam dist_t  RST_DETECT_ENTER   = 12'd300;
  localparam dist_t  RST_DETECT_EXIT    = 12'd730;
  localparam dist_t  RST_VALID_LIMIT    = 12'd900;
  localparam count_t RST_CLOSE_CONFIRM  = 8'd3;
  localparam count_t RST_DETECT_CONFIRM = 8'd1;
  localparam count_t RST_FAR_CONFIRM    = 8'd3;

  // x / 10 as (x * 52429) >> 19, exact for any 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    dist_t  close_enter;
    dist_t  close_exit;
    dist_t  detect_enter;
    dist_t  detect_exit;
    dist_t  valid_limit;
    count_t close_confirm;
    count_t detect_confirm;
    count_t far_confirm;
  } rzc_cfg_t;

  typedef struct packed {
    dist_t  smooth_dist;
    zone_t  zone;
    zone_t  reported_zone;
    count_t close_count;
    count_t detect_count;
    count_t far_count;
    logic   started;
  } rzc_state_t;

endpackage

/* hw/rtl/range_zone_classifier_unit.sv */
`timescale 1ns / 1ps

// range zone classifier
// sample channel: sample_valid / sample_stall with range_sample; a transfer
//   happens on a rising edge with sample_valid high and sample_stall low
// result channel: result_valid / result_stall with zone_changed, zone and
//   filtered_distance; one result per sample, in order
// config: cfg_we writes cfg_data into register cfg_index on the clock edge;
//   the user must write only while no sample is in flight (not enforced here)
// pipeline: a taken sample waits in the input stage and moves on to the result
//   register once that is empty or not stalled (two register stages: input, result)
// throughput: one sample per cycle while the receiver does not stall; the filter,
//   zone choice and counter update are combinational and feed the state register
// reset (rst, synchronous): registers go to their default values, filter
//   and zone state clear, both stages empty
// receiver stall: the result register holds; the input stage still takes
//   one more sample, then sample_stall rises until the result moves on
module range_zone_classifier_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  rzc_pkg::sample_t      range_sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  zone_changed,
  output logic [1:0]            zone,
  output rzc_pkg::dist_t        filtered_distance,
  input  logic                  cfg_we,
  input  rzc_pkg::reg_index_t   cfg_index,
  input  rzc_pkg::dist_t        cfg_data
);
  import rzc_pkg::*;

  rzc_cfg_t   cfg;
  rzc_state_t st;
  rzc_state_t st_next;
  logic       changed;
  logic       s1_valid;
  sample_t    s1_sample;
  logic       advance;
  logic       take;

  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !advance;
  assign take         = sample_valid && !sample_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.close_enter    <= RST_CLOSE_ENTER;
      cfg.close_exit     <= RST_CLOSE_EXIT;
      cfg.detect_enter   <= RST_DETECT_ENTER;
      cfg.detect_exit    <= RST_DETECT_EXIT;
      cfg.valid_limit    <= RST_VALID_LIMIT;
      cfg.close_confirm  <= RST_CLOSE_CONFIRM;
      cfg.detect_confirm <= RST_DETECT_CONFIRM;
      cfg.far_confirm    <= RST_FAR_CONFIRM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOSE_ENTER:    cfg.close_enter    <= cfg_data;
        REG_CLOSE_EXIT:     cfg.close_exit     <= cfg_data;
        REG_DETECT_ENTER:   cfg.detect_enter   <= cfg_data;
        REG_DETECT_EXIT:    cfg.detect_exit    <= cfg_data;
        REG_VALID_LIMIT:    cfg.valid_limit    <= cfg_data;
        REG_CLOSE_CONFIRM:  cfg.close_confirm  <= cfg_data[CountWidth-1:0];
        REG_DETECT_CONFIRM: cfg.detect_confirm <= cfg_data[CountWidth-1:0];
        REG_FAR_CONFIRM:    cfg.far_confirm    <= cfg_data[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sample <= range_sample;
    end
  end

  rzc_update u_update (
    .cfg     (cfg),
    .cur     (st),
    .sample  (s1_sample),
    .nxt     (st_next),
    .changed (changed)
  );

  // classifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.smooth_dist   <= '0;
      st.zone          <= ZONE_FAR;
      st.reported_zone <= ZONE_FAR;
      st.close_count   <= '0;
      st.detect_count  <= '0;
      st.far_count     <= '0;
      st.started       <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zone_changed      <= changed;
      zone              <= st_next.zone;
      filtered_distance <= st_next.smooth_dist;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !sample_stall)
    else $error("input stalled with empty input stage");

  a_advance_loads_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid && filtered_distance == st.smooth_dist)
    else $error("result register does not match updated state");

  a_counts_clear_on_change: assert property (@(posedge clk) disable iff (rst)
    advance && (st_next.zone != st.zone) |=>
      st.close_count == '0 && st.detect_count == '0 && st.far_count == '0)
    else $error("counters not cleared on zone change");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("state changed without a transfer");
`endif

endmodule

/* hw/rtl/rzc_update.sv */
`timescale 1ns / 1ps

module rzc_update (
  input  rzc_pkg::rzc_cfg_t   cfg,
  input  rzc_pkg::rzc_state_t cur,
  input  rzc_pkg::sample_t    sample,
  output rzc_pkg::rzc_state_t nxt,
  output logic                changed
);
  import rzc_pkg::*;

  logic [15:0] acc;
  logic [31:0] prod;
  dist_t       smooth;
  zone_t       proposed;
  zone_t       zone_new;
  count_t      cnt;

  // low-pass filter
  assign acc  = {1'b0, cur.smooth_dist, 3'b000} + {4'b0000, cur.smooth_dist}
              + {4'b0000, sample[DistWidth-1:0]};
  assign prod = acc * DIV10_MUL;

  always_comb begin
    nxt      = cur;
    smooth   = cur.smooth_dist;
    proposed = cur.zone;
    zone_new = cur.zone;
    cnt      = '0;

    if (sample < {4'b0000, cfg.valid_limit}) begin
      smooth = prod[DIV10_SHIFT +: DistWidth];
    end
    nxt.smooth_dist = smooth;

    // hysteresis
    unique case (cur.zone)
      ZONE_CLOSE: begin
        if (smooth > cfg.close_exit) proposed = ZONE_DETECT;
      end
      ZONE_DETECT: begin
        if (smooth < cfg.close_enter) proposed = ZONE_CLOSE;
        else if (smooth > cfg.detect_exit) proposed = ZONE_FAR;
      end
      default: begin
        if (smooth < cfg.detect_enter) proposed = ZONE_DETECT;
        else proposed = ZONE_FAR;
      end
    endcase

    // confirmation counters
    if (proposed == cur.zone) begin
      nxt.close_count  = '0;
      nxt.detect_count = '0;
      nxt.far_count    = '0;
    end else begin
      unique case (proposed)
        ZONE_CLOSE: begin
          cnt = cur.close_count + 8'd1;
          nxt.close_count = cnt;
          if (cnt >= cfg.close_confirm) zone_new = ZONE_CLOSE;
        end
        ZONE_DETECT: begin
          cnt = cur.detect_count + 8'd1;
          nxt.detect_count = cnt;
          if (cnt >= cfg.detect_confirm) zone_new = ZONE_DETECT;
        end
        default: begin
          cnt = cur.far_count + 8'd1;
          nxt.far_count = cnt;
          if (cnt >= cfg.far_confirm) zone_new = ZONE_FAR;
        end
      endcase
      if (zone_new != cur.zone) begin
        nxt.close_count  = '0;
        nxt.detect_count = '0;
        nxt.far_count    = '0;
      end
    end

    nxt.zone          = zone_new;
    changed           = !cur.started || (zone_new != cur.reported_zone);
    nxt.reported_zone = zone_new;
    nxt.started       = 1'b1;
  end

endmodule
